// ===== src/bam_pkg.sv =====
// ----------------------------------------------------------------------------
// bam_pkg: shared types and constants of the BAM LED plane driver
// Sizes of the shift-register chain, item structs and internal codes.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int NUM_REGS         = 12;
  localparam int CHANNELS_PER_REG = 15;
  localparam int PLANES           = 8;

  localparam int NUM_LEDS    = NUM_REGS * CHANNELS_PER_REG;
  localparam int STORE_DEPTH = NUM_REGS * PLANES;
  localparam int WORD_W      = CHANNELS_PER_REG;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int REG_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int BIT_W       = (CHANNELS_PER_REG > 1) ? $clog2(CHANNELS_PER_REG) : 1;
  localparam int PLANE_W     = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int SLOT_W      = $clog2(2 * PLANES);
  localparam int STEP_W      = (REG_W > PLANE_W) ? REG_W : PLANE_W;
  localparam int INTERVAL_W  = 16;

  // led / CHANNELS_PER_REG as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = 12;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + CHANNELS_PER_REG - 1) / CHANNELS_PER_REG;
  localparam int PROD_W    = 8 + DIV_SHIFT + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // input modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // configuration register indexes
  localparam logic REG_LSB_TIME = 1'b0;
  localparam logic REG_MIRRORED = 1'b1;

  // job kinds
  localparam logic JOB_WRITE = 1'b0;
  localparam logic JOB_SHOW  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] led_index;
    logic [7:0] brightness;
  } bam_in_t;

  typedef struct packed {
    logic [14:0] shift_word;
    logic [3:0]  register_index;
    logic [2:0]  plane;
    logic        latch_last;
  } bam_out_t;

  typedef struct packed {
    logic               kind;
    logic [REG_W-1:0]   reg_idx;
    logic [BIT_W-1:0]   bit_idx;
    logic [PLANES-1:0]  value;
    logic [PLANE_W-1:0] plane;
  } job_t;

endpackage

// ===== src/bam_front.sv =====
// ----------------------------------------------------------------------------
// bam_front: item intake and slot timing
// Splits LED writes into register/bit jobs, counts ticks down and queues a
// plane readout job whenever the current slot expires.
// ----------------------------------------------------------------------------
module bam_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bam_pkg::bam_in_t item,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output bam_pkg::job_t    q_job
);

  logic [7:0]                       lsb_time;
  logic                             mirrored_order;
  logic [bam_pkg::SLOT_W-1:0]       slot;
  logic [bam_pkg::INTERVAL_W-1:0]   interval_left;

  logic                             accept;
  logic [bam_pkg::PROD_W-1:0]       prod;
  logic [bam_pkg::REG_W-1:0]        reg_idx;
  logic [7:0]                       bit_full;
  logic                             in_range;
  logic                             expire;
  logic [bam_pkg::SLOT_W:0]         slot_inc;
  logic [bam_pkg::SLOT_W:0]         slot_count;
  logic [bam_pkg::SLOT_W-1:0]       slot_next;
  logic [bam_pkg::PLANE_W-1:0]      plane_next;
  logic [7:0]                       base;
  logic [bam_pkg::INTERVAL_W-1:0]   interval_next;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  always_comb begin
    prod     = bam_pkg::PROD_W'(item.led_index) * bam_pkg::PROD_W'(bam_pkg::DIV_RECIP);
    reg_idx  = bam_pkg::REG_W'(prod >> bam_pkg::DIV_SHIFT);
    bit_full = item.led_index - 8'(reg_idx * bam_pkg::CHANNELS_PER_REG);
    in_range = {1'b0, item.led_index} < 9'(bam_pkg::NUM_LEDS);

    expire     = !(interval_left > bam_pkg::INTERVAL_W'(1));
    slot_inc   = {1'b0, slot} + 1'b1;
    slot_count = mirrored_order ? (bam_pkg::SLOT_W + 1)'(2 * bam_pkg::PLANES)
                                : (bam_pkg::SLOT_W + 1)'(bam_pkg::PLANES);
    slot_next  = (slot_inc >= slot_count) ? '0 : bam_pkg::SLOT_W'(slot_inc);
    // second half of a mirrored run counts the planes back down
    if ({1'b0, slot_next} < (bam_pkg::SLOT_W + 1)'(bam_pkg::PLANES)) begin
      plane_next = bam_pkg::PLANE_W'(slot_next);
    end else begin
      plane_next = bam_pkg::PLANE_W'((bam_pkg::SLOT_W + 1)'(2 * bam_pkg::PLANES - 1)
                                     - {1'b0, slot_next});
    end
    base          = (lsb_time == 8'd0) ? 8'd1 : lsb_time;
    interval_next = bam_pkg::INTERVAL_W'(base) << plane_next;
  end

  always_comb begin
    q_job.kind    = (item.mode == bam_pkg::MODE_TICK) ? bam_pkg::JOB_SHOW : bam_pkg::JOB_WRITE;
    q_job.reg_idx = reg_idx;
    q_job.bit_idx = bam_pkg::BIT_W'(bit_full);
    q_job.value   = item.brightness[bam_pkg::PLANES-1:0];
    q_job.plane   = plane_next;
    if (item.mode == bam_pkg::MODE_WRITE) begin
      q_push = accept && in_range;
    end else begin
      q_push = accept && expire;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_time       <= 8'd32;
      mirrored_order <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bam_pkg::REG_LSB_TIME: lsb_time       <= cfg_data;
        bam_pkg::REG_MIRRORED: mirrored_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= bam_pkg::SLOT_W'(2 * bam_pkg::PLANES - 1);
      interval_left <= bam_pkg::INTERVAL_W'(1);
    end else if (accept && item.mode == bam_pkg::MODE_TICK) begin
      if (expire) begin
        slot          <= slot_next;
        interval_left <= interval_next;
      end else begin
        interval_left <= interval_left - 1'b1;
      end
    end
  end

endmodule

// ===== src/bam_queue.sv =====
// ----------------------------------------------------------------------------
// bam_queue: job queue between intake and plane engine
// Small FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module bam_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bam_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output bam_pkg::job_t job_out,
  output logic          empty
);

  bam_pkg::job_t               slots [bam_pkg::Q_DEPTH];
  logic [bam_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [bam_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [bam_pkg::Q_PTR_W:0]   count;

  assign full    = count == (bam_pkg::Q_PTR_W + 1)'(bam_pkg::Q_DEPTH);
  assign empty   = count == '0;
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (bam_pkg::Q_PTR_W + 1)'(push) - (bam_pkg::Q_PTR_W + 1)'(pop);
    end
  end

endmodule

// ===== src/bam_back.sv =====
// ----------------------------------------------------------------------------
// bam_back: plane store and readout engine
// Runs queued jobs: a write sets one bit in each plane word of a register,
// a show reads that plane's word for every register into a 2-entry output
// buffer.
// ----------------------------------------------------------------------------
module bam_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  bam_pkg::job_t     q_job,
  output logic              q_pop,
  output logic              word_valid,
  input  logic              word_stall,
  output bam_pkg::bam_out_t word
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_SHOW  = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  bam_pkg::job_t               cur;
  logic [bam_pkg::STEP_W-1:0]  step;

  logic [bam_pkg::WORD_W-1:0]  mem [bam_pkg::STORE_DEPTH];
  logic [bam_pkg::STORE_DEPTH-1:0] valid;

  logic                        wr_en;
  logic [bam_pkg::ADDR_W-1:0]  wr_addr;
  logic                        wr_bit;
  logic                        rd_issue;
  logic [bam_pkg::ADDR_W-1:0]  rd_addr;
  logic                        last_step;

  logic [bam_pkg::WORD_W-1:0]  rd_word;
  logic                        rd_ok;
  logic                        rd_pend;
  logic [bam_pkg::REG_W-1:0]   rd_reg;
  logic [bam_pkg::PLANE_W-1:0] rd_plane;

  bam_pkg::bam_out_t           obuf [2];
  logic                        head;
  logic [1:0]                  ocnt;
  logic                        take;
  logic [2:0]                  occ;
  bam_pkg::bam_out_t           new_word;

  assign take       = word_valid && !word_stall;
  assign word_valid = ocnt != 2'd0;
  assign word       = obuf[head];

  always_comb begin
    q_pop   = (state == ST_IDLE) && !q_empty;
    wr_en   = state == ST_WRITE;
    wr_addr = bam_pkg::ADDR_W'(cur.reg_idx * bam_pkg::PLANES + step);
    wr_bit  = cur.value[step[bam_pkg::PLANE_W-1:0]];
    rd_addr = bam_pkg::ADDR_W'(step * bam_pkg::PLANES + cur.plane);
    // words buffered plus one in flight must fit in two slots after this edge
    occ      = 3'(ocnt) + 3'(rd_pend);
    rd_issue = (state == ST_SHOW) && (occ < 3'd2 + 3'(take));
    if (state == ST_WRITE) begin
      last_step = step == bam_pkg::STEP_W'(bam_pkg::PLANES - 1);
    end else begin
      last_step = step == bam_pkg::STEP_W'(bam_pkg::NUM_REGS - 1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          state_next = (q_job.kind == bam_pkg::JOB_SHOW) ? ST_SHOW : ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (last_step) begin
          state_next = ST_IDLE;
        end
      end
      ST_SHOW: begin
        if (rd_issue && last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        step <= '0;
      end else if (wr_en || rd_issue) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  // plane store; an entry never written reads as all LEDs off
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (valid[wr_addr]) begin
        mem[wr_addr][cur.bit_idx] <= wr_bit;
      end else begin
        mem[wr_addr] <= bam_pkg::WORD_W'(wr_bit) << cur.bit_idx;
      end
    end
    if (rd_issue) begin
      rd_word  <= mem[rd_addr];
      rd_ok    <= valid[rd_addr];
      rd_reg   <= bam_pkg::REG_W'(step);
      rd_plane <= cur.plane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_pend <= rd_issue;
    end
  end

  always_comb begin
    new_word.shift_word     = 15'(rd_ok ? rd_word : '0);
    new_word.register_index = 4'(rd_reg);
    new_word.plane          = 3'(rd_plane);
    new_word.latch_last     = rd_reg == bam_pkg::REG_W'(bam_pkg::NUM_REGS - 1);
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      obuf[head ^ ocnt[0]] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (take) begin
        head <= ~head;
      end
      ocnt <= ocnt + 2'(rd_pend) - 2'(take);
    end
  end

endmodule

// ===== src/bam_led_plane_driver.sv =====
// ----------------------------------------------------------------------------
// bam_led_plane_driver: bit-angle-modulation LED driver
// Bit-plane store for 180 LEDs on 12 shift registers of 15 channels.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall / item): mode 0 writes one LED's
// brightness into the 8 bit planes, mode 1 is one timer tick. Writes to an
// LED beyond the chain are dropped. item_stall is high while the job queue
// (4 entries) is full.
// Output channel (word_valid / word_stall / word): when a tick ends the
// current slot, the next plane's word goes out for registers 0..11, one per
// cycle while word_stall is low, the last one flagged latch_last.
// A write occupies the plane engine for each plane word of the register, one
// per cycle on the single store write port; a readout for each register.
// Ticks that do not end a slot and dropped writes take no engine time.
// word_stall holds the 2-entry output buffer; reads pause until room frees,
// and the queue absorbs up to 4 further jobs before item_stall rises.
// Configuration: cfg_write with cfg_index 0 sets lsb_time, 1 sets the
// mirrored slot order; write only while idle.
// Reset (rst, synchronous): all LEDs off with no clearing pass, lsb_time 32,
// plain order, and the first tick shows plane 0.
// ----------------------------------------------------------------------------
module bam_led_plane_driver (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bam_pkg::bam_in_t  item,
  output logic              word_valid,
  input  logic              word_stall,
  output bam_pkg::bam_out_t word,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  bam_pkg::job_t q_job_in;
  bam_pkg::job_t q_job_out;

  bam_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job_in)
  );

  bam_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (q_job_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_job_out),
    .empty   (q_empty)
  );

  bam_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_job_out),
    .q_pop      (q_pop),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word       (word)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_latch_on_last: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> (word.latch_last == (word.register_index == 4'(bam_pkg::NUM_REGS - 1))))
    else $error("latch mark not on the last register word");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> ({1'b0, word.plane} < 4'(bam_pkg::PLANES)))
    else $error("word carries a plane beyond the store");

endmodule
